// ===== hdl/fvn_pkg.sv =====
// Shared constants, types and tables for the fractal value noise block.
// Used by the interfaces, every module of the block and the checker.
`timescale 1ns / 1ps

package fvn_pkg;

   localparam int MAX_OCTAVES     = 8;

   localparam int COORD_WIDTH     = 32;
   localparam int NOISE_WIDTH     = 16;
   localparam int SEED_WIDTH      = 32;
   localparam int COUNT_REG_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int OCT_INDEX_WIDTH = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int OCT_COUNT_WIDTH = $clog2(MAX_OCTAVES + 1);

   localparam int FRAC_WIDTH      = 16;
   localparam int LATTICE_WIDTH   = 24;
   localparam int ROW_WIDTH       = 41;
   localparam int SUM_WIDTH       = 56;

   // pipeline layout: input register, octave lanes, adder tree, normaliser
   localparam int LANE_STAGES     = 5;
   localparam int TREE_LEVELS     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int TREE_SIZE       = 1 << TREE_LEVELS;
   localparam int NORM_STAGES     = 3;
   localparam int LANE_FIRST      = 1;
   localparam int TREE_FIRST      = LANE_FIRST + LANE_STAGES;
   localparam int NORM_FIRST      = TREE_FIRST + TREE_LEVELS;
   localparam int PIPE_DEPTH      = NORM_FIRST + NORM_STAGES;

   localparam logic [31:0] HASH_MUL_X       = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y       = 32'd668265263;
   localparam logic [31:0] HASH_MUL_SEED    = 32'd2147483647;
   localparam logic [31:0] HASH_MUL_MIX     = 32'd1274126177;
   localparam logic [31:0] OCTAVE_SEED_STEP = 32'd101;

   localparam logic [16:0] ONE_Q16      = 17'h10000;
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

   // hash offsets of the four corners, index {dy, dx}
   localparam logic [31:0] CORNER_OFFSET [4] = '{
      32'd0, HASH_MUL_X, HASH_MUL_Y, HASH_MUL_X + HASH_MUL_Y
   };

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NOISE_SEED   = 1'b0,
      CSR_OCTAVE_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LANE_STAGES-1:0] load;
   } lane_ctrl_type;

   typedef struct packed {
      logic [TREE_LEVELS-1:0] load;
   } tree_ctrl_type;

   typedef struct packed {
      logic [NORM_STAGES-1:0] load;
   } norm_ctrl_type;

   // floor(2^32 / (2^n - 1)); all ones stands in for n = 1
   function automatic logic [31:0] div_recip(input logic [COUNT_REG_WIDTH-1:0] n);
      logic [31:0] r;
      unique case (n)
         4'd2:    r = 32'h55555555;
         4'd3:    r = 32'h24924924;
         4'd4:    r = 32'h11111111;
         4'd5:    r = 32'h08421084;
         4'd6:    r = 32'h04104104;
         4'd7:    r = 32'h02040810;
         4'd8:    r = 32'h01010101;
         4'd9:    r = 32'h00804020;
         4'd10:   r = 32'h00401004;
         4'd11:   r = 32'h00200400;
         4'd12:   r = 32'h00100100;
         default: r = 32'hFFFFFFFF;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/fvn_if.sv =====
// Request and response channel interfaces of the fractal value noise block.
// Depends on fvn_pkg for the field widths.
`timescale 1ns / 1ps

interface fvn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fvn_pkg::COORD_WIDTH-1:0] x_coord;
   logic signed [fvn_pkg::COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface fvn_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fvn_pkg::NOISE_WIDTH-1:0]  noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== hdl/fvn_octave.sv =====
// One octave lane: lattice hash of four corners, smoothstep and bilinear blend.
// Five register stages; depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_octave (
   input  logic                                   clock,
   input  fvn_pkg::lane_ctrl_type                 ctrl,
   input  logic [fvn_pkg::OCT_INDEX_WIDTH-1:0]    octave_index,
   input  logic [fvn_pkg::SEED_WIDTH-1:0]         noise_seed,
   input  logic signed [fvn_pkg::COORD_WIDTH-1:0] x_coord,
   input  logic signed [fvn_pkg::COORD_WIDTH-1:0] y_coord,
   output logic [fvn_pkg::SUM_WIDTH-1:0]          octave_value
);
   import fvn_pkg::*;

   // stage 1: scale, cell products, squared fractions
   logic [47:0] x_scaled, y_scaled;
   logic [31:0] seed_oct;
   logic [31:0] px_in, py_in, ps_in, px_ff, py_ff, ps_ff;
   logic [31:0] tx_sq_in, ty_sq_in, tx_sq_ff, ty_sq_ff;
   logic [FRAC_WIDTH-1:0] tx_ff, ty_ff;

   assign x_scaled = {{16{x_coord[31]}}, x_coord} << octave_index;
   assign y_scaled = {{16{y_coord[31]}}, y_coord} << octave_index;
   assign seed_oct = noise_seed + 32'(octave_index) * OCTAVE_SEED_STEP;
   assign px_in    = x_scaled[47:16] * HASH_MUL_X;
   assign py_in    = y_scaled[47:16] * HASH_MUL_Y;
   assign ps_in    = seed_oct * HASH_MUL_SEED;
   assign tx_sq_in = 32'(x_scaled[15:0]) * 32'(x_scaled[15:0]);
   assign ty_sq_in = 32'(y_scaled[15:0]) * 32'(y_scaled[15:0]);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         ps_ff    <= ps_in;
         tx_sq_ff <= tx_sq_in;
         ty_sq_ff <= ty_sq_in;
         tx_ff    <= x_scaled[15:0];
         ty_ff    <= y_scaled[15:0];
      end
   end

   // stage 2: corner sums, first xorshift, smoothstep
   logic [31:0] hash_base;
   logic [31:0] corner [4];
   logic [31:0] premix_in [4];
   logic [31:0] premix_ff [4];
   logic [17:0] fac_x, fac_y;
   logic [49:0] smooth_x_prod, smooth_y_prod;
   logic [FRAC_WIDTH-1:0] sx_ff, sy_ff;

   assign hash_base = px_ff + py_ff + ps_ff;

   for (genvar k = 0; k < 4; k++) begin : g_corner
      assign corner[k]    = hash_base + CORNER_OFFSET[k];
      assign premix_in[k] = corner[k] ^ (corner[k] >> 13);
   end

   assign fac_x         = SMOOTH_THREE - {1'b0, tx_ff, 1'b0};
   assign fac_y         = SMOOTH_THREE - {1'b0, ty_ff, 1'b0};
   assign smooth_x_prod = 50'(tx_sq_ff) * 50'(fac_x);
   assign smooth_y_prod = 50'(ty_sq_ff) * 50'(fac_y);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         premix_ff <= premix_in;
         sx_ff     <= smooth_x_prod[47:32];
         sy_ff     <= smooth_y_prod[47:32];
      end
   end

   // stage 3: mixing multiply, blend weights
   logic [31:0] mixed_in [4];
   logic [31:0] mixed_ff [4];
   logic [16:0] wx_lo_ff, wy_lo_s3_ff;
   logic [FRAC_WIDTH-1:0] wx_hi_ff, wy_hi_s3_ff;

   for (genvar k = 0; k < 4; k++) begin : g_mix
      assign mixed_in[k] = premix_ff[k] * HASH_MUL_MIX;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         mixed_ff    <= mixed_in;
         wx_lo_ff    <= ONE_Q16 - 17'(sx_ff);
         wx_hi_ff    <= sx_ff;
         wy_lo_s3_ff <= ONE_Q16 - 17'(sy_ff);
         wy_hi_s3_ff <= sy_ff;
      end
   end

   // stage 4: lattice values and blend along x
   logic [31:0] folded [4];
   logic [LATTICE_WIDTH-1:0] lattice [4];
   logic [ROW_WIDTH-1:0] row0_in, row1_in, row0_ff, row1_ff;
   logic [16:0] wy_lo_s4_ff;
   logic [FRAC_WIDTH-1:0] wy_hi_s4_ff;

   for (genvar k = 0; k < 4; k++) begin : g_lattice
      assign folded[k]  = mixed_ff[k] ^ (mixed_ff[k] >> 16);
      assign lattice[k] = folded[k][LATTICE_WIDTH-1:0];
   end

   assign row0_in = ROW_WIDTH'(lattice[0]) * ROW_WIDTH'(wx_lo_ff)
                  + ROW_WIDTH'(lattice[1]) * ROW_WIDTH'(wx_hi_ff);
   assign row1_in = ROW_WIDTH'(lattice[2]) * ROW_WIDTH'(wx_lo_ff)
                  + ROW_WIDTH'(lattice[3]) * ROW_WIDTH'(wx_hi_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         row0_ff     <= row0_in;
         row1_ff     <= row1_in;
         wy_lo_s4_ff <= wy_lo_s3_ff;
         wy_hi_s4_ff <= wy_hi_s3_ff;
      end
   end

   // stage 5: blend along y, octave weight
   logic [57:0] blend;
   logic [OCT_INDEX_WIDTH:0] weight_shift;
   logic [SUM_WIDTH-1:0] octave_in, octave_ff;

   assign blend        = 58'(row0_ff) * 58'(wy_lo_s4_ff) + 58'(row1_ff) * 58'(wy_hi_s4_ff);
   assign weight_shift = {1'b0, octave_index} + (OCT_INDEX_WIDTH+1)'(1);
   assign octave_in    = SUM_WIDTH'(blend >> weight_shift);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         octave_ff <= octave_in;
      end
   end

   assign octave_value = octave_ff;

endmodule

// ===== hdl/fvn_sum_tree.sv =====
// Registered adder tree over the octave lanes, dropping octaves beyond the count.
// Depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_sum_tree (
   input  logic                                clock,
   input  fvn_pkg::tree_ctrl_type              ctrl,
   input  logic [fvn_pkg::OCT_COUNT_WIDTH-1:0] octave_count,
   input  logic [fvn_pkg::SUM_WIDTH-1:0]       octave_value [fvn_pkg::MAX_OCTAVES],
   output logic [fvn_pkg::SUM_WIDTH-1:0]       sum_value
);
   import fvn_pkg::*;

   logic [SUM_WIDTH-1:0] leaf [TREE_SIZE];
   logic [SUM_WIDTH-1:0] node_ff [TREE_LEVELS][TREE_SIZE/2];

   for (genvar j = 0; j < TREE_SIZE; j++) begin : g_leaf
      if (j < MAX_OCTAVES) begin : g_lane
         assign leaf[j] = (OCT_COUNT_WIDTH'(j) < octave_count) ? octave_value[j] : '0;
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
      for (genvar j = 0; j < (TREE_SIZE >> (l + 1)); j++) begin : g_node
         if (l == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (ctrl.load[l]) begin
                  node_ff[l][j] <= leaf[2*j] + leaf[2*j+1];
               end
            end
         end else begin : g_upper
            always_ff @(posedge clock) begin
               if (ctrl.load[l]) begin
                  node_ff[l][j] <= node_ff[l-1][2*j] + node_ff[l-1][2*j+1];
               end
            end
         end
      end
   end

   assign sum_value = node_ff[TREE_LEVELS-1][0];

endmodule

// ===== hdl/fvn_normalize.sv =====
// Divides the octave sum by the summed weights via a reciprocal table,
// with remainder correction, then saturates to Q0.16. Depends on fvn_pkg.
`timescale 1ns / 1ps

module fvn_normalize (
   input  logic                                clock,
   input  fvn_pkg::norm_ctrl_type              ctrl,
   input  logic [fvn_pkg::OCT_COUNT_WIDTH-1:0] octave_count,
   input  logic [fvn_pkg::SUM_WIDTH-1:0]       sum_value,
   output logic [fvn_pkg::NOISE_WIDTH-1:0]     noise_value
);
   import fvn_pkg::*;

   logic [MAX_OCTAVES-1:0] divisor;
   logic [31:0] recip;

   assign divisor = MAX_OCTAVES'(((MAX_OCTAVES+1)'(1) << octave_count)
                                 - (MAX_OCTAVES+1)'(1));
   assign recip   = div_recip(COUNT_REG_WIDTH'(octave_count));

   // stage 1: quotient estimate, low by at most one
   logic [31:0] scaled_in, scaled_s1_ff, quot_s1_ff;
   logic [63:0] est_prod;

   assign scaled_in = sum_value[SUM_WIDTH-1:SUM_WIDTH-32];
   assign est_prod  = 64'(scaled_in) * 64'(recip);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         scaled_s1_ff <= scaled_in;
         quot_s1_ff   <= est_prod[63:32];
      end
   end

   // stage 2: multiply back
   logic [31:0] back_in, back_ff, scaled_s2_ff, quot_s2_ff;

   assign back_in = quot_s1_ff * 32'(divisor);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         back_ff      <= back_in;
         scaled_s2_ff <= scaled_s1_ff;
         quot_s2_ff   <= quot_s1_ff;
      end
   end

   // stage 3: correct, add, saturate
   logic [31:0] remainder;
   logic        bump;
   logic [33:0] total;
   logic [NOISE_WIDTH-1:0] noise_in, noise_ff;

   assign remainder = scaled_s2_ff - back_ff;
   assign bump      = (remainder >= 32'(divisor));
   assign total     = 34'(scaled_s2_ff) + 34'(quot_s2_ff) + 34'(bump);

   always_comb begin
      if (octave_count == '0) begin
         noise_in = '0;
      end else if (|total[33:32]) begin
         noise_in = '1;
      end else begin
         noise_in = total[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         noise_ff <= noise_in;
      end
   end

   assign noise_value = noise_ff;

endmodule

// ===== hdl/fractal_value_noise_2d.sv =====
// Fractal value noise over a 2D Q16.16 coordinate: one request per clock while
// the response side does not stall. A request passes an input register, the
// five-stage octave lanes running all eight octaves side by side, a three-level
// adder tree and a three-stage reciprocal normaliser. The pipeline holds up to
// 12 requests; a stalled response only blocks new requests once every stage is
// full. Registers: noise_seed (index 0) and octave_count (index 1, counts
// above eight act as eight, zero gives zero); write them only while idle.
`timescale 1ns / 1ps

module fractal_value_noise_2d (
   input  logic                               clock,
   input  logic                               reset,
   fvn_req_if.sink                            req_if,
   fvn_rsp_if.source                          rsp_if,
   input  logic                               csr_write_en,
   input  fvn_pkg::csr_index_type             csr_index,
   input  logic [fvn_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import fvn_pkg::*;

   // configuration registers
   logic [SEED_WIDTH-1:0]      noise_seed_in, noise_seed_ff;
   logic [COUNT_REG_WIDTH-1:0] octave_count_in, octave_count_ff;
   logic [OCT_COUNT_WIDTH-1:0] octave_active;

   always_comb begin
      noise_seed_in   = noise_seed_ff;
      octave_count_in = octave_count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NOISE_SEED:   noise_seed_in   = csr_write_data[SEED_WIDTH-1:0];
            CSR_OCTAVE_COUNT: octave_count_in = csr_write_data[COUNT_REG_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff   <= '0;
         octave_count_ff <= COUNT_REG_WIDTH'(4);
      end else begin
         noise_seed_ff   <= noise_seed_in;
         octave_count_ff <= octave_count_in;
      end
   end

   assign octave_active = (octave_count_ff > COUNT_REG_WIDTH'(MAX_OCTAVES))
                        ? OCT_COUNT_WIDTH'(MAX_OCTAVES)
                        : OCT_COUNT_WIDTH'(octave_count_ff);

   // pipeline control: a stage advances when the response is taken or when it or any stage after it is empty
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;
   logic [PIPE_DEPTH-1:0] advance;

   for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_advance
      assign advance[k] = rsp_if.ready || !(&valid_ff[PIPE_DEPTH-1:k]);
   end

   always_comb begin
      valid_in[0] = advance[0] ? req_if.valid : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready = advance[0];
   assign rsp_if.valid = valid_ff[PIPE_DEPTH-1];

   // input register
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         x_ff <= req_if.x_coord;
         y_ff <= req_if.y_coord;
      end
   end

   lane_ctrl_type lane_ctrl;
   tree_ctrl_type tree_ctrl;
   norm_ctrl_type norm_ctrl;

   assign lane_ctrl.load = advance[TREE_FIRST-1:LANE_FIRST];
   assign tree_ctrl.load = advance[NORM_FIRST-1:TREE_FIRST];
   assign norm_ctrl.load = advance[PIPE_DEPTH-1:NORM_FIRST];

   logic [SUM_WIDTH-1:0] octave_value [MAX_OCTAVES];
   logic [SUM_WIDTH-1:0] sum_value;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      fvn_octave u_octave (
         .clock        (clock),
         .ctrl         (lane_ctrl),
         .octave_index (OCT_INDEX_WIDTH'(i)),
         .noise_seed   (noise_seed_ff),
         .x_coord      (x_ff),
         .y_coord      (y_ff),
         .octave_value (octave_value[i])
      );
   end

   fvn_sum_tree u_sum_tree (
      .clock        (clock),
      .ctrl         (tree_ctrl),
      .octave_count (octave_active),
      .octave_value (octave_value),
      .sum_value    (sum_value)
   );

   fvn_normalize u_normalize (
      .clock        (clock),
      .ctrl         (norm_ctrl),
      .octave_count (octave_active),
      .sum_value    (sum_value),
      .noise_value  (rsp_if.noise_value)
   );

endmodule

// ===== hdl/fvn_checker.sv =====
// Port-level checker for fractal_value_noise_2d, attached by the bind below.
// Depends on fvn_pkg for the pipeline depth and register codes.
`timescale 1ns / 1ps

module fvn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [fvn_pkg::NOISE_WIDTH-1:0]    noise_value,
   input logic                               csr_write_en,
   input fvn_pkg::csr_index_type             csr_index,
   input logic [fvn_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import fvn_pkg::*;

   localparam int OUT_WIDTH = $clog2(PIPE_DEPTH + 2);

   logic [OUT_WIDTH-1:0]       pending_in, pending_ff;
   logic [COUNT_REG_WIDTH-1:0] count_in, count_ff;
   logic                       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + OUT_WIDTH'(req_fire) - OUT_WIDTH'(rsp_fire);
      count_in   = count_ff;
      if (csr_write_en && csr_index == CSR_OCTAVE_COUNT) begin
         count_in = csr_write_data[COUNT_REG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= COUNT_REG_WIDTH'(4);
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
      else $error("response dropped or changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response with no request in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= OUT_WIDTH'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_zero_octaves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_ff == '0 |-> noise_value == '0)
      else $error("non-zero noise with zero octaves");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .noise_value    (rsp_if.noise_value),
   .csr_write_en   (csr_write_en),
   .csr_index      (csr_index),
   .csr_write_data (csr_write_data)
);
